[sv/fbpa_pkg.sv]
package fbpa_pkg;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int BS_W     = 17;
    localparam int NUM_W    = 11;
    localparam int STATUS_W = 3;

    // Pool geometry
    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // Register port
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = PADDR_W - 2;

    // Reset values and lower limits of the configuration
    localparam int BS_RESET  = 64;
    localparam int NUM_RESET = 1024;
    localparam int BS_MIN    = 2;
    localparam int NUM_MIN   = 2;
    localparam int CNT_RESET = (NUM_RESET > MAX_BLOCKS) ? MAX_BLOCKS : NUM_RESET;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NUM_BLOCKS = 2'd2;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_OOM        = 3'd1,
        STAT_MISALIGNED = 3'd2,
        STAT_RANGE      = 3'd3,
        STAT_FULL       = 3'd4
    } status_t;

endpackage

[sv/fbpa_req_if.sv]
interface fbpa_req_if;
    import fbpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

[sv/fbpa_rsp_if.sv]
interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, output status, output block_address, input ready);
    modport sink   (input valid, input status, input block_address, output ready);
endinterface

[sv/fixed_block_pool_allocator_top.sv]
// An allocate on an empty pool goes straight from S_PREP to S_FIN; an allocate runs a
// 10-step shift-add multiplier for the block offset, and a free runs a
// 32-step shift-subtract divider by the block size.
// One request at a time; a new beat can be taken in the cycle after the previous result is
// loaded into the output register, while that result may still wait for its sink.
// Reset (rst_n low, asynchronous): default configuration, all blocks free, ring as 0..N-1.
module fixed_block_pool_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    fbpa_req_if.sink                      req,
    fbpa_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [fbpa_pkg::DATA_W-1:0]   pwdata,
    output logic [fbpa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import fbpa_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_MUL_LD = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_CHK    = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    // Saturate the block count into its legal range
    function automatic logic [CNT_W-1:0] eff_count(input logic [NUM_W-1:0] num);
        logic [CNT_W-1:0] n;
        if (32'(num) < 32'(NUM_MIN))
            n = CNT_W'(NUM_MIN);
        else if (32'(num) > 32'(MAX_BLOCKS))
            n = CNT_W'(MAX_BLOCKS);
        else
            n = CNT_W'(num);
        return n;
    endfunction

    // Saturate the block size at its minimum
    function automatic logic [BS_W-1:0] eff_size(input logic [BS_W-1:0] bs);
        logic [BS_W-1:0] s;
        if (bs < BS_W'(BS_MIN))
            s = BS_W'(BS_MIN);
        else
            s = bs;
        return s;
    endfunction

    // Control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   pool_base_reg, pool_base_next;
    logic [BS_W-1:0]     block_size_reg, block_size_next;
    logic [NUM_W-1:0]    num_blocks_reg, num_blocks_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath
    logic                kind_reg, kind_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                neg_reg, neg_next;
    logic [ADDR_W-1:0]   quo_reg, quo_next;
    logic [BS_W-1:0]     rem_reg, rem_next;
    logic [ADDR_W-1:0]   acc_reg, acc_next;
    logic [ADDR_W-1:0]   mcand_reg, mcand_next;
    logic [IDX_W-1:0]    mplier_reg, mplier_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    rd_head_reg, rd_head_next;
    status_t             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    status_t             out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;

    // Free ring storage
    logic [IDX_W-1:0]    ring_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]    ring_rd_reg;
    logic                ring_we;
    logic [IDX_W-1:0]    ring_waddr;

    // Helpers
    logic [CNT_W-1:0]    n_eff;
    logic [BS_W-1:0]     bs_eff;
    logic [CNT_W:0]      tail_sum;
    logic [CNT_W:0]      tail_wrap;
    logic [CNT_W-1:0]    head_inc;
    logic [ADDR_W:0]     diff_fwd;
    logic [ADDR_W-1:0]   diff_rev;
    logic [BS_W:0]       div_shift;
    logic [BS_W+1:0]     div_trial;
    logic [ADDR_W-1:0]   mul_sum;
    logic                cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign n_eff    = eff_count(num_blocks_reg);
    assign bs_eff   = eff_size(block_size_reg);
    assign cfg_we   = psel & penable & pwrite & pready;
    assign cfg_idx  = paddr[PADDR_W-1:2];
    assign pready   = 1'b1;

    // Tail of the ring: head plus count, wrapped once
    assign tail_sum   = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail_wrap  = (tail_sum >= (CNT_W+1)'(n_eff)) ? tail_sum - (CNT_W+1)'(n_eff)
                                                        : tail_sum;
    assign ring_waddr = tail_wrap[IDX_W-1:0];
    assign head_inc   = CNT_W'(head_reg) + CNT_W'(1);

    // Signed distance from the pool base
    assign diff_fwd = {1'b0, addr_reg} - {1'b0, pool_base_reg};
    assign diff_rev = pool_base_reg - addr_reg;

    // One divider step and one multiplier step
    assign div_shift = {rem_reg, quo_reg[ADDR_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, bs_eff};
    assign mul_sum   = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.block_address = out_addr_reg;

    // Register readback
    always_comb
    begin
        case (cfg_idx)
            REG_POOL_BASE:  prdata = pool_base_reg;
            REG_BLOCK_SIZE: prdata = DATA_W'(block_size_reg);
            REG_NUM_BLOCKS: prdata = DATA_W'(num_blocks_reg);
            default:        prdata = '0;
        endcase
    end

    // Sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        pool_base_next  = pool_base_reg;
        block_size_next = block_size_reg;
        num_blocks_next = num_blocks_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        neg_next        = neg_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        step_next       = step_reg;
        hit_next        = hit_reg;
        rd_head_next    = rd_head_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        ring_we         = 1'b0;

        // Drop the result once the sink takes it
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    addr_next  = req.address;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = STAT_OOM;
                        res_addr_next   = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        // Pop the head; the ring read lands next cycle
                        hit_next     = (CNT_W'(head_reg) < fill_reg);
                        rd_head_next = head_reg;
                        head_next    = (head_inc == n_eff) ? '0 : head_inc[IDX_W-1:0];
                        count_next   = count_reg - CNT_W'(1);
                        state_next   = S_MUL_LD;
                    end
                end
                else
                begin
                    neg_next   = diff_fwd[ADDR_W];
                    quo_next   = diff_fwd[ADDR_W] ? diff_rev : diff_fwd[ADDR_W-1:0];
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end

            S_MUL_LD:
            begin
                // Entries past the fill mark still hold their own index
                mplier_next = hit_reg ? ring_rd_reg : rd_head_reg;
                acc_next    = pool_base_reg;
                mcand_next  = ADDR_W'(bs_eff);
                step_next   = '0;
                state_next  = S_MUL;
            end

            S_MUL:
            begin
                acc_next    = mul_sum;
                mcand_next  = {mcand_reg[ADDR_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(IDX_W - 1))
                begin
                    res_status_next = STAT_OK;
                    res_addr_next   = mul_sum;
                    state_next      = S_FIN;
                end
            end

            S_DIV:
            begin
                if (!div_trial[BS_W+1])
                begin
                    rem_next = div_trial[BS_W-1:0];
                    quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift[BS_W-1:0];
                    quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ADDR_W - 1))
                    state_next = S_CHK;
            end

            S_CHK:
            begin
                res_addr_next = '0;
                if (rem_reg != '0)
                    res_status_next = STAT_MISALIGNED;
                else if (neg_reg || (quo_reg >= ADDR_W'(n_eff)))
                    res_status_next = STAT_RANGE;
                else if (count_reg >= n_eff)
                    res_status_next = STAT_FULL;
                else
                begin
                    // Append the block index at the tail
                    res_status_next = STAT_OK;
                    ring_we         = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    if (fill_reg < n_eff)
                        fill_next = fill_reg + CNT_W'(1);
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Write a register and rebuild the ring
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_POOL_BASE:  pool_base_next  = pwdata;
                REG_BLOCK_SIZE: block_size_next = pwdata[BS_W-1:0];
                REG_NUM_BLOCKS: num_blocks_next = pwdata[NUM_W-1:0];
                default:        ;
            endcase
            if (cfg_idx inside {REG_POOL_BASE, REG_BLOCK_SIZE, REG_NUM_BLOCKS})
            begin
                head_next  = '0;
                count_next = eff_count(num_blocks_next);
                fill_next  = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pool_base_reg  <= '0;
            block_size_reg <= BS_W'(BS_RESET);
            num_blocks_reg <= NUM_W'(NUM_RESET);
            head_reg       <= '0;
            count_reg      <= CNT_W'(CNT_RESET);
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pool_base_reg  <= pool_base_next;
            block_size_reg <= block_size_next;
            num_blocks_reg <= num_blocks_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        neg_reg        <= neg_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        step_reg       <= step_next;
        hit_reg        <= hit_next;
        rd_head_reg    <= rd_head_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    // Ring memory: one write port at the tail, registered read at the head
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_waddr] <= quo_reg[IDX_W-1:0];
        ring_rd_reg <= ring_mem[head_reg];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= n_eff)
        else $error("free count exceeds block count");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(head_reg) < n_eff)
        else $error("ring head outside the pool");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STAT_OK)) |-> (rsp.block_address == '0))
        else $error("failed request returns a nonzero address");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");
`endif

endmodule
